// ===== hdl/bsm_pkg.sv =====
// Shared types and constants for the block signal metrics unit.
package bsm_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned RootW    = 16;
  localparam int unsigned LenW     = 13;
  localparam int unsigned RegAddrW = 3;
  localparam int unsigned DataW    = 32;

  localparam logic [SampleW-1:0] ThreshReset = 16'd6554;

  // Register index, taken from paddr[2]
  localparam logic RegIdxThresh = 1'b0;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_value;
    logic                      is_last;
  } sample_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] mean_value;
    logic [RootW-1:0]          rms_value;
    logic [SampleW-1:0]        peak_value;
    logic [SampleW-1:0]        peak_excess;
    logic                      stable_flag;
    logic [LenW-1:0]           block_length;
  } metrics_out_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic div_step;
    logic root_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic block_end;
  } dp_status_t;

endpackage

// ===== hdl/bsm_ctrl.sv =====
// Sequencer for accumulation, division, square root and result hand-off.
module bsm_ctrl
  import bsm_pkg::*;
#(
  parameter int unsigned MAX_COUNT = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam int unsigned CntW  = $clog2(MAX_COUNT + 1);
  localparam int unsigned SqW   = 32 + CntW;
  localparam int unsigned StepW = $clog2(SqW);

  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_ACC: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.block_end) begin
            cmd_o.start = 1'b1;
            step_d      = '0;
            state_d     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == StepW'(SqW - 1)) begin
          step_d  = '0;
          state_d = ST_ROOT;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (step_q == StepW'(RootW - 1)) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (state_q == ST_ACC);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/bsm_dp.sv =====
// Accumulators, shared-step dividers, square root and output register.
module bsm_dp
  import bsm_pkg::*;
#(
  parameter int unsigned MAX_COUNT = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  sample_in_t         in_data_i,
  input  logic [SampleW-1:0] threshold_i,
  output metrics_out_t       out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_COUNT + 1);
  localparam int unsigned SumW = 17 + CntW;
  localparam int unsigned SqW  = 32 + CntW;
  localparam int unsigned RemW = RootW + 2;

  // running block state
  logic [CntW-1:0]        cnt_q;
  logic signed [SumW-1:0] sum_q;
  logic [SqW-1:0]         sq_q;
  logic [SampleW-1:0]     peak_q;

  // block snapshot and iteration state
  logic [CntW-1:0]    div_q;
  logic               neg_q;
  logic [SqW-1:0]     numa_q, numa_d;
  logic [SqW-1:0]     numb_q, numb_d;
  logic [CntW-1:0]    rema_q, rema_d;
  logic [CntW-1:0]    remb_q, remb_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [RemW-1:0]    rrem_q, rrem_d;
  logic [SampleW-1:0] pkw_q;
  metrics_out_t       out_q, out_d;

  logic signed [SampleW:0] s_ext, mag_ext;
  logic [SampleW-1:0]      mag;
  logic [2*SampleW-1:0]    sq_inc;
  logic [CntW-1:0]         cnt_nx;
  logic signed [SumW-1:0]  sum_nx, sum_abs;
  logic [SqW-1:0]          sq_nx;
  logic [SampleW-1:0]      peak_nx;
  logic [CntW:0]           sha, shb, diffa, diffb;
  logic [RemW+1:0]         racc, rtrial, rdiff;
  logic [SampleW:0]        noise_w;
  logic [SampleW-1:0]      mean_q16;

  assign s_ext   = (SampleW + 1)'(in_data_i.sample_value);
  assign mag_ext = s_ext[SampleW] ? -s_ext : s_ext;
  assign mag     = mag_ext[SampleW-1:0];
  assign sq_inc  = mag * mag;
  assign cnt_nx  = cnt_q + CntW'(1);
  assign sum_nx  = sum_q + SumW'(in_data_i.sample_value);
  assign sq_nx   = sq_q + SqW'(sq_inc);
  assign peak_nx = (mag > peak_q) ? mag : peak_q;
  assign sum_abs = sum_nx[SumW-1] ? -sum_nx : sum_nx;

  assign status_o.block_end = in_data_i.is_last || (cnt_q == CntW'(MAX_COUNT - 1));

  // restoring division, one quotient bit per lane per step; restoring square root, one root bit per step
  always_comb begin
    sha    = {rema_q, numa_q[SqW-1]};
    shb    = {remb_q, numb_q[SqW-1]};
    diffa  = sha - {1'b0, div_q};
    diffb  = shb - {1'b0, div_q};
    rema_d = rema_q;
    remb_d = remb_q;
    numa_d = numa_q;
    numb_d = numb_q;
    rtrial = {2'b00, root_q, 2'b01};
    racc   = {rrem_q, numb_q[31:30]};
    rdiff  = racc - rtrial;
    rrem_d = rrem_q;
    root_d = root_q;
    if (cmd_i.div_step) begin
      if (sha >= {1'b0, div_q}) begin
        rema_d = diffa[CntW-1:0];
        numa_d = {numa_q[SqW-2:0], 1'b1};
      end else begin
        rema_d = sha[CntW-1:0];
        numa_d = {numa_q[SqW-2:0], 1'b0};
      end
      if (shb >= {1'b0, div_q}) begin
        remb_d = diffb[CntW-1:0];
        numb_d = {numb_q[SqW-2:0], 1'b1};
      end else begin
        remb_d = shb[CntW-1:0];
        numb_d = {numb_q[SqW-2:0], 1'b0};
      end
    end else if (cmd_i.root_step) begin
      numb_d = {numb_q[SqW-3:0], 2'b00};
      if (racc >= rtrial) begin
        rrem_d = rdiff[RemW-1:0];
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rrem_d = racc[RemW-1:0];
        root_d = {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign mean_q16 = numa_q[SampleW-1:0];
  assign noise_w  = ({1'b0, pkw_q} >= {1'b0, root_q}) ?
                    ({1'b0, pkw_q} - {1'b0, root_q}) : '0;

  always_comb begin
    out_d              = out_q;
    out_d.mean_value   = neg_q ? -mean_q16 : mean_q16;
    out_d.rms_value    = root_q;
    out_d.peak_value   = pkw_q;
    out_d.peak_excess  = noise_w[SampleW-1:0];
    out_d.stable_flag  = (noise_w[SampleW-1:0] < threshold_i);
    out_d.block_length = LenW'(div_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      peak_q <= '0;
    end else if (cmd_i.accept) begin
      if (cmd_i.start) begin
        cnt_q  <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
        peak_q <= '0;
      end else begin
        cnt_q  <= cnt_nx;
        sum_q  <= sum_nx;
        sq_q   <= sq_nx;
        peak_q <= peak_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      div_q  <= cnt_nx;
      neg_q  <= sum_nx[SumW-1];
      numa_q <= SqW'(unsigned'(sum_abs));
      numb_q <= sq_nx;
      rema_q <= '0;
      remb_q <= '0;
      root_q <= '0;
      rrem_q <= '0;
      pkw_q  <= peak_nx;
    end else begin
      numa_q <= numa_d;
      numb_q <= numb_d;
      rema_q <= rema_d;
      remb_q <= remb_d;
      root_q <= root_d;
      rrem_q <= rrem_d;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/block_signal_metrics.sv =====
// Top level of the block signal metrics unit with its register port.
//
// Samples are taken one per cycle while a block accumulates. The last sample
// of a block (marked, or the MAX_COUNT-th) starts the result computation, and
// the input holds off until it is finished: the division steps, the square-root
// steps and the load of the output register, and longer while an earlier result
// still waits in the output register. The two divisions (sum and sum of squares
// by the count) run side by side, one quotient bit per cycle; the square root
// then produces one result bit per cycle. A finished result waits in the output
// register while the next block accumulates.
module block_signal_metrics
  import bsm_pkg::*;
#(
  parameter int unsigned MAX_COUNT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sample_in_t          in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output metrics_out_t        out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic [SampleW-1:0] thresh_q;
  logic               thresh_we;
  logic [SampleW:0]   mean_mag;

  assign pready    = 1'b1;
  assign thresh_we = psel && penable && pwrite && pready && (paddr[2] == RegIdxThresh);
  assign prdata    = (paddr[2] == RegIdxThresh) ? DataW'(thresh_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (thresh_we) begin
      thresh_q <= pwdata[SampleW-1:0];
    end
  end

  bsm_ctrl #(
    .MAX_COUNT(MAX_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsm_dp #(
    .MAX_COUNT(MAX_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .threshold_i(thresh_q),
    .out_data_o (out_data_o)
  );

  assign mean_mag = out_data_o.mean_value[SampleW-1] ?
                    -((SampleW + 1)'(out_data_o.mean_value)) :
                    (SampleW + 1)'(out_data_o.mean_value);

  a_noise_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_data_o.peak_excess} + {1'b0, out_data_o.rms_value}
                     == {1'b0, out_data_o.peak_value}))
    else $error("noise plus rms differs from peak");

  a_mean_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mean_mag <= {1'b0, out_data_o.peak_value}))
    else $error("mean magnitude above peak");

  a_load_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result loaded while input was open");

endmodule
